// File: hw/rtl/pareto_frontier_keeper_defines.svh
// Assertion macros for the Pareto frontier keeper checker.
`ifndef PARETO_FRONTIER_KEEPER_DEFINES_SVH
`define PARETO_FRONTIER_KEEPER_DEFINES_SVH

// Flag a condition that must never be seen at a clock edge.
`define PFK_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("pfk: forbidden condition seen");

// Require a consequence in the cycle after an antecedent.
`define PFK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pfk: expected follow-up missing");

`endif

// File: hw/rtl/pfk_pkg.sv
// Types and constants shared by the Pareto frontier keeper.
package pfk_pkg;

	localparam int COUNT_OUT_W = 7;
	localparam logic [31:0] BUDGET_RESET = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        point_valid;
		logic [31:0] buffer_bytes;
		logic [47:0] access_bytes;
		logic [15:0] point_tag;
	} in_item_t;

	typedef struct packed {
		logic                   kept;
		logic                   overflow;
		logic [COUNT_OUT_W-1:0] removed_count;
		logic [COUNT_OUT_W-1:0] frontier_count;
		logic                   found;
		logic [31:0]            best_buffer;
		logic [47:0]            best_access;
		logic [15:0]            best_tag;
	} out_item_t;

	typedef struct packed {
		logic [31:0] buf_bytes;
		logic [47:0] acc_bytes;
		logic [15:0] tag;
	} entry_t;

	typedef struct packed {
		logic ent_beats_new;
		logic new_beats_ent;
		logic take;
	} cmp_res_t;

endpackage

// File: hw/rtl/pareto_frontier_keeper.sv
// Pareto frontier keeper: top level with the scan sequencer.
// Keeps an ordered two-key frontier of up to FRONTIER_DEPTH points in a single-port-read
// store and returns one result per request. A new request is taken only after the
// previous one has loaded its result register. One shared compare unit walks the store
// one point a cycle from the registered read port, checking dominance, compacting survivors
// in place and tracking the best fitting point. After the walk drains, ST_APPEND appends
// the new point if it survives and fits, and ST_FINISH loads the result register. The
// input stalls for the whole walk, and while a result is held by the output stall, the next
// request waits in ST_FINISH to load the result register, with the input still stalled.
// The budget register may be written only while no request is open.
module pareto_frontier_keeper #(
	parameter int FRONTIER_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [31:0]         cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  pfk_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output pfk_pkg::out_item_t  out_item
);

	localparam int AW = $clog2(FRONTIER_DEPTH);
	localparam int CW = $clog2(FRONTIER_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(FRONTIER_DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_APPEND = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t              state_q;
	logic [31:0]         budget_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       rd_idx_q;
	logic                rd_pend_q;
	logic [CW-1:0]       w_q;
	logic [CW-1:0]       removed_q;
	logic                dom_q;
	logic                found_q;
	logic                kept_q;
	logic                ovf_q;
	logic                pt_valid_q;
	pfk_pkg::entry_t     pt_q;
	pfk_pkg::entry_t     best_q;
	pfk_pkg::out_item_t  out_q;
	logic                out_valid_q;

	pfk_pkg::entry_t     rd_data;
	pfk_pkg::entry_t     cmp_ent;
	pfk_pkg::entry_t     wr_data;
	pfk_pkg::cmp_res_t   cres;
	logic                rd_en;
	logic                wr_en;
	logic                drop_ent;
	logic                append_ok;
	logic                out_free;

	always_comb begin
		rd_en     = (state_q == ST_SCAN) && (rd_idx_q < count_q);
		drop_ent  = pt_valid_q && cres.new_beats_ent;
		append_ok = pt_valid_q && !dom_q && (w_q < DEPTH_C);
		cmp_ent   = (state_q == ST_APPEND) ? pt_q : rd_data;
		wr_data   = (state_q == ST_APPEND) ? pt_q : rd_data;
		wr_en     = ((state_q == ST_SCAN) && rd_pend_q && !drop_ent) ||
			((state_q == ST_APPEND) && append_ok);
		out_free  = !out_valid_q || !out_stall;
	end

	pfk_mem #(
		.DEPTH(FRONTIER_DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (wr_en),
		.waddr (w_q[AW-1:0]),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (rd_data)
	);

	pfk_cmp u_cmp (
		.pt       (pt_q),
		.ent      (cmp_ent),
		.budget   (budget_q),
		.found    (found_q),
		.best_acc (best_q.acc_bytes),
		.res      (cres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			budget_q    <= pfk_pkg::BUDGET_RESET;
			count_q     <= '0;
			rd_idx_q    <= '0;
			rd_pend_q   <= 1'b0;
			w_q         <= '0;
			removed_q   <= '0;
			dom_q       <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				budget_q <= cfg_wdata;
			end
			if (out_valid_q && !out_stall && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						rd_idx_q  <= '0;
						rd_pend_q <= 1'b0;
						w_q       <= '0;
						removed_q <= '0;
						dom_q     <= 1'b0;
						found_q   <= 1'b0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					rd_pend_q <= rd_en;
					if (rd_en) begin
						rd_idx_q <= CW'(rd_idx_q + 1'b1);
					end
					if (rd_pend_q) begin
						if (drop_ent) begin
							removed_q <= CW'(removed_q + 1'b1);
						end else begin
							w_q <= CW'(w_q + 1'b1);
							if (cres.take) begin
								found_q <= 1'b1;
							end
						end
						if (pt_valid_q && cres.ent_beats_new) begin
							dom_q <= 1'b1;
						end
					end
					if (!rd_en && !rd_pend_q) begin
						state_q <= ST_APPEND;
					end
				end
				ST_APPEND: begin
					if (append_ok) begin
						count_q <= CW'(w_q + 1'b1);
						if (cres.take) begin
							found_q <= 1'b1;
						end
					end else begin
						count_q <= w_q;
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					pt_valid_q       <= in_item.point_valid;
					pt_q.buf_bytes   <= in_item.buffer_bytes;
					pt_q.acc_bytes   <= in_item.access_bytes;
					pt_q.tag         <= in_item.point_tag;
					best_q           <= '0;
				end
			end
			ST_SCAN: begin
				if (rd_pend_q && !drop_ent && cres.take) begin
					best_q <= rd_data;
				end
			end
			ST_APPEND: begin
				kept_q <= append_ok;
				ovf_q  <= pt_valid_q && !dom_q && !(w_q < DEPTH_C);
				if (append_ok && cres.take) begin
					best_q <= pt_q;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					out_q.kept           <= kept_q;
					out_q.overflow       <= ovf_q;
					out_q.removed_count  <= pfk_pkg::COUNT_OUT_W'(removed_q);
					out_q.frontier_count <= pfk_pkg::COUNT_OUT_W'(count_q);
					out_q.found          <= found_q;
					out_q.best_buffer    <= best_q.buf_bytes;
					out_q.best_access    <= best_q.acc_bytes;
					out_q.best_tag       <= best_q.tag;
				end
			end
			default: begin
				best_q <= best_q;
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// File: hw/rtl/pfk_mem.sv
// Frontier point store: one write port, one registered read port.
module pfk_mem #(
	parameter int DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [$clog2(DEPTH)-1:0]        waddr,
	input  pfk_pkg::entry_t                 wdata,
	input  logic                            re,
	input  logic [$clog2(DEPTH)-1:0]        raddr,
	output pfk_pkg::entry_t                 rdata
);

	pfk_pkg::entry_t mem_q [DEPTH];
	pfk_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/pfk_cmp.sv
// Shared compare unit: dominance both ways and best-fit selection.
module pfk_cmp (
	input  pfk_pkg::entry_t   pt,
	input  pfk_pkg::entry_t   ent,
	input  logic [31:0]       budget,
	input  logic              found,
	input  logic [47:0]       best_acc,
	output pfk_pkg::cmp_res_t res
);

	logic buf_lt;
	logic buf_gt;
	logic acc_lt;
	logic acc_gt;

	always_comb begin
		buf_lt = ent.buf_bytes < pt.buf_bytes;
		buf_gt = ent.buf_bytes > pt.buf_bytes;
		acc_lt = ent.acc_bytes < pt.acc_bytes;
		acc_gt = ent.acc_bytes > pt.acc_bytes;
		res.ent_beats_new = (acc_lt && !buf_gt) || (buf_lt && !acc_gt);
		res.new_beats_ent = (acc_gt && !buf_lt) || (buf_gt && !acc_lt);
		res.take = (ent.buf_bytes <= budget) && (!found || (ent.acc_bytes < best_acc));
	end

endmodule

// File: hw/rtl/pfk_chk.sv
// Port-level checker for the Pareto frontier keeper, bound to the top level.
`include "pareto_frontier_keeper_defines.svh"

module pfk_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input pfk_pkg::out_item_t out_item
);

	logic best_nonzero;

	assign best_nonzero = |{out_item.best_buffer, out_item.best_access, out_item.best_tag};

	`PFK_NEVER(a_kept_and_ovf, out_valid && out_item.kept && out_item.overflow)
	`PFK_NEVER(a_ovf_no_removal, out_valid && out_item.overflow && (out_item.removed_count != 0))
	`PFK_NEVER(a_none_reads_zero, out_valid && !out_item.found && best_nonzero)
	`PFK_NEXT(a_busy_after_request, in_valid && !in_stall, in_stall)
	`PFK_NEXT(a_result_held, out_valid && out_stall, out_valid && $stable(out_item))

endmodule

bind pareto_frontier_keeper pfk_chk u_pfk_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

// File: verif/tb_pareto_frontier_keeper.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Pareto frontier keeper: directed and random point traffic.
module tb_pareto_frontier_keeper;

	localparam int FRONTIER_DEPTH = 64;
	localparam int MAX_CYCLES = 1000000;
	localparam int PHASES = 8;
	localparam int PHASE_REQUESTS = 175;
	localparam int STAIR_LEN = 72;
	localparam int PRINT_CAP = 40;
	localparam logic [31:0] DIR_SIZE = 32'hA000_0000;
	localparam logic [47:0] DIR_MOVED = 48'hA000_0000_0000;

	class frontier_book;
		pfk_pkg::entry_t held[$];
		pfk_pkg::out_item_t expected_reports[$];
		logic [31:0] budget;
		int errors;

		function new();
			budget = pfk_pkg::BUDGET_RESET;
			errors = 0;
		endfunction

		function bit outranks(pfk_pkg::entry_t a, pfk_pkg::entry_t b);
			return (a.acc_bytes < b.acc_bytes && a.buf_bytes <= b.buf_bytes) ||
				(a.buf_bytes < b.buf_bytes && a.acc_bytes <= b.acc_bytes);
		endfunction

		function void note_request(pfk_pkg::in_item_t req);
			pfk_pkg::entry_t cand;
			pfk_pkg::entry_t survivors[$];
			pfk_pkg::out_item_t rep;
			bit beaten;
			int removed;
			rep = '0;
			removed = 0;
			beaten = 1'b0;
			cand = {req.buffer_bytes, req.access_bytes, req.point_tag};
			if (req.point_valid) begin
				foreach (held[i])
					if (outranks(held[i], cand)) beaten = 1'b1;
				if (!beaten) begin
					foreach (held[i]) begin
						if (outranks(cand, held[i])) removed++;
						else survivors = {survivors, held[i]};
					end
					held = survivors;
					if (held.size() < FRONTIER_DEPTH) begin
						held = {held, cand};
						rep.kept = 1'b1;
					end else begin
						rep.overflow = 1'b1;
					end
				end
			end
			rep.removed_count = pfk_pkg::COUNT_OUT_W'(removed);
			rep.frontier_count = pfk_pkg::COUNT_OUT_W'(held.size());
			foreach (held[i]) begin
				if (held[i].buf_bytes <= budget &&
					(!rep.found || held[i].acc_bytes < rep.best_access)) begin
					rep.found = 1'b1;
					rep.best_buffer = held[i].buf_bytes;
					rep.best_access = held[i].acc_bytes;
					rep.best_tag = held[i].tag;
				end
			end
			expected_reports = {expected_reports, rep};
		endfunction

		task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			if (errors < PRINT_CAP)
				$display("%0t mismatch %s: got %h want %h", $time, what, got, want);
			errors++;
		endtask

		task check_field(string what, logic [63:0] got, logic [63:0] want);
			if (got !== want) report_mismatch(what, got, want);
		endtask

		task check_result(pfk_pkg::out_item_t got);
			pfk_pkg::out_item_t want;
			if (expected_reports.size() == 0) begin
				report_mismatch("result with no request open", 64'(got.frontier_count), 64'd0);
			end else begin
				want = expected_reports.pop_front();
				check_field("kept", 64'(got.kept), 64'(want.kept));
				check_field("overflow", 64'(got.overflow), 64'(want.overflow));
				check_field("removed_count", 64'(got.removed_count), 64'(want.removed_count));
				check_field("frontier_count", 64'(got.frontier_count), 64'(want.frontier_count));
				check_field("found", 64'(got.found), 64'(want.found));
				check_field("best_buffer", 64'(got.best_buffer), 64'(want.best_buffer));
				check_field("best_access", 64'(got.best_access), 64'(want.best_access));
				check_field("best_tag", 64'(got.best_tag), 64'(want.best_tag));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [31:0] cfg_wdata;
	logic in_valid;
	logic in_stall;
	pfk_pkg::in_item_t in_item;
	logic out_valid;
	logic out_stall;
	pfk_pkg::out_item_t out_item;

	frontier_book book;
	int level = 0;
	int requests_sent = 0;
	int stall_left = 0;
	int cycle_count = 0;
	bit idle_en = 1'b1;

	pareto_frontier_keeper #(
		.FRONTIER_DEPTH(FRONTIER_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (idle_en && $urandom_range(0, 11) == 0) begin
			stall_left = $urandom_range(0, 10);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
			book.check_result(out_item);
	end

	initial begin
		while (cycle_count < MAX_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_pareto_frontier_keeper failed");
		$finish;
	end

	function automatic pfk_pkg::in_item_t pack_request(logic valid, logic [31:0] size_b,
		logic [47:0] moved_b, logic [15:0] tag);
		pfk_pkg::in_item_t r;
		r.point_valid = valid;
		r.buffer_bytes = size_b;
		r.access_bytes = moved_b;
		r.point_tag = tag;
		return r;
	endfunction

	// Grid point on the current level; each level sits lower in both keys.
	function automatic pfk_pkg::in_item_t grid_request(int x, int y, bit jitter);
		logic [63:0] size_b;
		logic [63:0] moved_b;
		size_b = 64'h8000_0000 - 64'(level) * 64'h0080_0000 + 64'(x) * 64'h0010_0000;
		moved_b = 64'h8000_0000_0000 - 64'(level) * 64'h0800_0000 + 64'(y) * 64'h0100_0000;
		if (jitter) begin
			size_b += 64'($urandom_range(0, 32'h000F_FFFF));
			moved_b += 64'($urandom_range(0, 32'h00FF_FFFF));
		end
		return pack_request(1'b1, size_b[31:0], moved_b[47:0], 16'($urandom));
	endfunction

	// Keep noise points out of the grid region so they never block it.
	function automatic pfk_pkg::in_item_t noise_request();
		logic [47:0] wide;
		wide = 48'({$urandom, $urandom});
		case ($urandom_range(0, 2))
			0: return pack_request(1'b0, $urandom, wide, 16'($urandom));
			1: return pack_request(1'b1, $urandom, {2'b11, wide[45:0]}, 16'($urandom));
			default: return pack_request(1'b1, {2'b11, 30'($urandom)}, wide, 16'($urandom));
		endcase
	endfunction

	task automatic send_request(pfk_pkg::in_item_t req);
		int gap;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_item <= req;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		book.note_request(req);
		requests_sent++;
	endtask

	task automatic drain();
		@(negedge clk) in_valid <= 1'b0;
		while (book.expected_reports.size() != 0) @(posedge clk);
		repeat (FRONTIER_DEPTH + 8) @(posedge clk);
	endtask

	task automatic write_budget(logic [31:0] value);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		book.budget = value;
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	task automatic run_directed();
		send_request(pack_request(1'b0, '1, '1, '1));
		send_request(pack_request(1'b1, '1, '1, '1));
		send_request(pack_request(1'b0, '0, '0, '0));
		send_request(pack_request(1'b1, DIR_SIZE + 32'h1000, DIR_MOVED + 48'h1000, 16'h0001));
		send_request(pack_request(1'b1, DIR_SIZE + 32'h1000, DIR_MOVED + 48'h1000, 16'h0002));
		send_request(pack_request(1'b1, DIR_SIZE + 32'h2000, DIR_MOVED + 48'h2000, 16'h0003));
		send_request(pack_request(1'b1, DIR_SIZE + 32'h1000, DIR_MOVED + 48'h2000, 16'h0004));
		send_request(pack_request(1'b1, DIR_SIZE + 32'h0800, DIR_MOVED + 48'h1000, 16'h0005));
		send_request(pack_request(1'b1, DIR_SIZE + 32'h1000, DIR_MOVED + 48'h0800, 16'h0006));
		send_request(pack_request(1'b1, DIR_SIZE + 32'h0C00, DIR_MOVED + 48'h0C00, 16'h0007));
		send_request(pack_request(1'b1, 32'h0, '1, 16'h0008));
		send_request(pack_request(1'b1, '1, 48'h0, 16'h0009));
		write_budget(32'h0);
		send_request(pack_request(1'b0, $urandom, 48'h0, 16'h0));
		send_request(pack_request(1'b1, 32'h0, '1, 16'h000A));
		write_budget(DIR_SIZE + 32'h0FFF);
		send_request(pack_request(1'b0, 32'h0, 48'h0, 16'h0));
		send_request(pack_request(1'b1, DIR_SIZE + 32'h0C00, DIR_MOVED + 48'h0C00, 16'h000B));
		send_request(pack_request(1'b1, DIR_SIZE + 32'h0A00, DIR_MOVED + 48'h0C00, 16'h000C));
	endtask

	// Strictly rising size with falling traffic: nothing shadows anything, so the store fills.
	task automatic run_staircase();
		bit jit;
		jit = $urandom_range(0, 1);
		level++;
		for (int i = 0; i < STAIR_LEN; i++)
			send_request(grid_request(i, STAIR_LEN - 1 - i, jit));
	endtask

	task automatic run_cluster();
		int n;
		int x;
		bit jit;
		pfk_pkg::in_item_t last;
		n = $urandom_range(15, 40);
		jit = $urandom_range(0, 1);
		if ($urandom_range(0, 1)) level++;
		last = grid_request(30, 33, jit);
		repeat (n) begin
			x = $urandom_range(0, 60);
			case ($urandom_range(0, 19))
				0, 1, 2: send_request(noise_request());
				3, 4: begin
					last.point_tag = 16'($urandom);
					send_request(last);
				end
				default: begin
					last = grid_request(x, 66 - x - int'($urandom_range(0, 6)), jit);
					send_request(last);
				end
			endcase
		end
	endtask

	task automatic run_phase(int p);
		int start;
		logic [63:0] mid;
		logic [31:0] budget_value;
		idle_en = (p < PHASES - 2) && (p != 3);
		mid = 64'h8000_0000 - 64'(level) * 64'h0080_0000 +
			64'($urandom_range(0, 70)) * 64'h0010_0000;
		case (p)
			1: budget_value = '1;
			3: budget_value = '0;
			5, 7: budget_value = $urandom;
			default: budget_value = mid[31:0];
		endcase
		write_budget(budget_value);
		start = requests_sent;
		if (p == 0) run_staircase();
		while (requests_sent - start < PHASE_REQUESTS) begin
			case ($urandom_range(0, 9))
				0: run_staircase();
				9: repeat ($urandom_range(3, 8)) send_request(noise_request());
				default: run_cluster();
			endcase
		end
	endtask

	initial begin
		book = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		run_directed();
		for (int p = 0; p < PHASES; p++)
			run_phase(p);
		drain();
		if (book.errors == 0 && book.expected_reports.size() == 0) begin
			$display("tb_pareto_frontier_keeper passed");
		end else begin
			$display("tb_pareto_frontier_keeper failed");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/pfk_pkg.sv
hw/rtl/pfk_mem.sv
hw/rtl/pfk_cmp.sv
hw/rtl/pareto_frontier_keeper.sv
hw/rtl/pfk_chk.sv
verif/tb_pareto_frontier_keeper.sv
